// ===== rtl/grb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package grb_pkg;

    localparam int unsigned FRAME_WIDTH = 1024;
    localparam int unsigned PIXEL_BYTES = 2;
    localparam logic [31:0] ROW_BYTES   = 32'(FRAME_WIDTH * PIXEL_BYTES);
    localparam logic [31:0] PIX_STEP    = 32'(PIXEL_BYTES);
    localparam logic [23:0] COLOR_MASK  = (PIXEL_BYTES > 2) ? 24'hFFFFFF : 24'h00FFFF;

    localparam logic [4:0] MAX_COLS    = 5'd16;
    localparam logic [4:0] WIDTH_WIDE  = 5'd12;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 56;

    typedef enum logic [2:0] {
        CFG_TEXT_COLOR  = 3'd0,
        CFG_BACK_COLOR  = 3'd1,
        CFG_OPAQUE      = 3'd2,
        CFG_ORIGIN_X    = 3'd3,
        CFG_ORIGIN_Y    = 3'd4,
        CFG_GLYPH_WIDTH = 3'd5,
        CFG_FRAME_BASE  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINE,
        ST_FIRST,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic line;
        logic first;
        logic step;
    } grb_cmd_t;

    typedef struct packed {
        logic last;
    } grb_status_t;

endpackage

`default_nettype wire

// ===== rtl/grb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module grb_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire grb_pkg::grb_status_t status,
    output grb_pkg::grb_cmd_t        cmd
);
    import grb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LINE;
                end
            end
            ST_LINE: begin
                cmd.line   = 1'b1;
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                cmd.first  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/grb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module grb_datapath (
    input  wire logic                aclk,
    input  wire logic                cfg_wr,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                aresetn,
    input  wire logic [15:0]         row_bits,
    input  wire logic [5:0]          row_index,
    input  wire logic [4:0]          col_start,
    input  wire logic [4:0]          col_end,
    input  wire grb_pkg::grb_cmd_t   cmd,
    output grb_pkg::grb_status_t     status,
    output logic [31:0]              byte_address,
    output logic [23:0]              pixel_color,
    output logic                     write_enable
);
    import grb_pkg::*;

    logic [23:0] text_color_reg;
    logic [23:0] back_color_reg;
    logic        opaque_reg;
    logic [11:0] origin_x_reg;
    logic [11:0] origin_y_reg;
    logic [4:0]  glyph_width_reg;
    logic [31:0] frame_base_reg;

    logic [15:0] bits_reg;
    logic [5:0]  row_reg;
    logic [4:0]  col_reg;
    logic [4:0]  end_reg;
    logic        empty_reg;
    logic [31:0] line_reg;
    logic [31:0] addr_reg;

    logic [4:0]  end_sat;
    logic [12:0] row_sum;
    logic [12:0] col_sum;
    logic        bit_on;
    logic [3:0]  col_lo;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg  <= 24'hFFFFFF;
            back_color_reg  <= 24'h000000;
            opaque_reg      <= 1'b1;
            origin_x_reg    <= 12'd0;
            origin_y_reg    <= 12'd0;
            glyph_width_reg <= 5'd8;
            frame_base_reg  <= 32'd0;
        end else if (cfg_wr) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TEXT_COLOR:  text_color_reg  <= cfg_data[23:0];
                CFG_BACK_COLOR:  back_color_reg  <= cfg_data[23:0];
                CFG_OPAQUE:      opaque_reg      <= cfg_data[0];
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_data[11:0];
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data[11:0];
                CFG_GLYPH_WIDTH: glyph_width_reg <= cfg_data[4:0];
                CFG_FRAME_BASE:  frame_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign end_sat = (col_end > MAX_COLS) ? MAX_COLS : col_end;
    assign row_sum = {1'b0, origin_y_reg} + {7'd0, row_reg};
    assign col_sum = {1'b0, origin_x_reg} + {8'd0, col_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bits_reg  <= row_bits;
            row_reg   <= row_index;
            col_reg   <= col_start;
            end_reg   <= end_sat;
            empty_reg <= (col_start >= end_sat);
        end else if (cmd.step) begin
            col_reg   <= col_reg + 5'd1;
        end
        if (cmd.line) begin
            line_reg <= 32'(row_sum) * ROW_BYTES;
        end
        if (cmd.first) begin
            addr_reg <= empty_reg ? 32'd0
                      : frame_base_reg + line_reg + 32'(col_sum) * PIX_STEP;
        end else if (cmd.step) begin
            addr_reg <= addr_reg + PIX_STEP;
        end
    end

    assign col_lo = col_reg[3:0];

    // bit order follows the glyph width
    always_comb begin
        if (glyph_width_reg < WIDTH_WIDE) begin
            bit_on = !col_reg[3] && bits_reg[4'd7 - col_lo];
        end else if (glyph_width_reg == WIDTH_WIDE) begin
            bit_on = bits_reg[4'd15 - col_lo];
        end else begin
            bit_on = bits_reg[col_lo];
        end
    end

    always_comb begin
        byte_address = addr_reg;
        write_enable = 1'b0;
        pixel_color  = 24'd0;
        if (!empty_reg) begin
            if (bit_on) begin
                write_enable = 1'b1;
                pixel_color  = text_color_reg & COLOR_MASK;
            end else if (opaque_reg) begin
                write_enable = 1'b1;
                pixel_color  = back_color_reg & COLOR_MASK;
            end
        end
    end

    assign status.last = empty_reg || (({1'b0, col_reg} + 6'd1) == {1'b0, end_reg});

endmodule

`default_nettype wire

// ===== rtl/glyph_row_blitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Glyph row blitter: takes one font glyph row per request (bits, row index and a
// column window) and issues one framebuffer pixel write per column of the window,
// left to right, with tlast on the final one; tuser is the write enable, low when
// a clear bit meets transparent mode. An empty window gives a single result with
// address 0, no write and tlast. Steps: the request is taken, the line address
// is multiplied, the first-column address is added, then one pixel goes out per
// cycle while m_tready is high, for n results in all (1 to 16); a new item is
// taken only in the cycle after the last result of the previous one has gone
// out. Configuration is accepted every cycle and must only be written while
// the block is idle.

module glyph_row_blitter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // row_bits, row_index, col_start, col_end
    input  wire logic [grb_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [grb_pkg::M_TDATA_W-1:0]          m_tdata,   // byte_address, pixel_color
    output logic                                   m_tuser,   // write_enable
    output logic                                   m_tlast
);
    import grb_pkg::*;

    grb_cmd_t    cmd;
    grb_status_t status;
    logic [31:0] byte_address;
    logic [23:0] pixel_color;

    assign cfg_ready = 1'b1;

    grb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grb_datapath u_datapath (
        .aclk         (aclk),
        .cfg_wr       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .aresetn      (aresetn),
        .row_bits     (s_tdata[15:0]),
        .row_index    (s_tdata[21:16]),
        .col_start    (s_tdata[26:22]),
        .col_end      (s_tdata[31:27]),
        .cmd          (cmd),
        .status       (status),
        .byte_address (byte_address),
        .pixel_color  (pixel_color),
        .write_enable (m_tuser)
    );

    assign m_tdata = {pixel_color, byte_address};
    assign m_tlast = status.last;

endmodule

`default_nettype wire

// ===== rtl/grb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module grb_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // one row at a time
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while results pending");

    // taken request closes the input
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("input still open after request taken");

    // no write means no color
    a_nocolor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[55:32] == 24'd0)
        else $error("color on a no-write result");

    // row done frees the input
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("input not freed after last result");

endmodule

bind glyph_row_blitter grb_checker u_grb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
